// ===== src/condition_code_flag_unit_defines.svh =====
// assertion macros for the condition code flag unit checker
`ifndef CONDITION_CODE_FLAG_UNIT_DEFINES_SVH
`define CONDITION_CODE_FLAG_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CCFU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccfu check failed");

// next-cycle implication, sampled on clk, off during reset
`define CCFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccfu check failed");

`endif

// ===== src/ccfu_pkg.sv =====
// shared widths, rule codes, condition codes and flag functions
package ccfu_pkg;

    localparam int DATA_W  = 32;
    localparam int SHIFT_W = 6;
    localparam int IDX_W   = 5;
    localparam int FLAG_W  = 5;

    localparam int FLAG_X_BIT = 4;
    localparam int FLAG_N_BIT = 3;
    localparam int FLAG_Z_BIT = 2;
    localparam int FLAG_V_BIT = 1;
    localparam int FLAG_C_BIT = 0;

    // action
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_TEST   = 1'b1;

    // operand size
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    // x rule
    localparam logic X_COPY_C = 1'b1;

    // n rule
    localparam logic [1:0] N_SIGN   = 2'd1;
    localparam logic [1:0] N_TOGGLE = 2'd2;

    // z rule
    localparam logic [1:0] Z_KEEP   = 2'd0;
    localparam logic [1:0] Z_TOGGLE = 2'd1;
    localparam logic [1:0] Z_ZERO   = 2'd2;
    localparam logic [1:0] Z_STICKY = 2'd3;

    // v rule
    localparam logic [2:0] V_CLEAR  = 3'd1;
    localparam logic [2:0] V_TOGGLE = 3'd2;
    localparam logic [2:0] V_ADD    = 3'd3;
    localparam logic [2:0] V_SUB    = 3'd4;
    localparam logic [2:0] V_DR     = 3'd5;

    // c rule
    localparam logic [3:0] C_TOGGLE  = 4'd1;
    localparam logic [3:0] C_CLEAR   = 4'd2;
    localparam logic [3:0] C_COPY_X  = 4'd3;
    localparam logic [3:0] C_SHR_OUT = 4'd4;
    localparam logic [3:0] C_SHL_OUT = 4'd5;
    localparam logic [3:0] C_DR_SIGN = 4'd6;
    localparam logic [3:0] C_ADD     = 4'd7;
    localparam logic [3:0] C_SUB     = 4'd8;

    // branch conditions
    localparam logic [3:0] COND_T  = 4'd0;
    localparam logic [3:0] COND_F  = 4'd1;
    localparam logic [3:0] COND_HI = 4'd2;
    localparam logic [3:0] COND_LS = 4'd3;
    localparam logic [3:0] COND_CC = 4'd4;
    localparam logic [3:0] COND_CS = 4'd5;
    localparam logic [3:0] COND_NE = 4'd6;
    localparam logic [3:0] COND_EQ = 4'd7;
    localparam logic [3:0] COND_VC = 4'd8;
    localparam logic [3:0] COND_VS = 4'd9;
    localparam logic [3:0] COND_PL = 4'd10;
    localparam logic [3:0] COND_MI = 4'd11;
    localparam logic [3:0] COND_GE = 4'd12;
    localparam logic [3:0] COND_LT = 4'd13;
    localparam logic [3:0] COND_GT = 4'd14;
    localparam logic [3:0] COND_LE = 4'd15;

    typedef struct packed {
        logic               action;
        logic               x_rule;
        logic [1:0]         n_rule;
        logic [1:0]         z_rule;
        logic [2:0]         v_rule;
        logic [3:0]         c_rule;
        logic [DATA_W-1:0]  src_operand;
        logic [DATA_W-1:0]  dst_operand;
        logic [DATA_W-1:0]  alu_result;
        logic [1:0]         operand_size;
        logic [SHIFT_W-1:0] shift_count;
        logic [3:0]         cond_select;
    } item_t;

    // new flags for an update transaction
    function automatic logic [FLAG_W-1:0] flags_update(input item_t it,
                                                       input logic [FLAG_W-1:0] f);
        logic [DATA_W-1:0]  mask;
        logic [DATA_W-1:0]  s;
        logic [DATA_W-1:0]  d;
        logic [DATA_W-1:0]  r;
        logic [SHIFT_W-1:0] span;
        logic [SHIFT_W-1:0] rpos;
        logic [SHIFT_W-1:0] lpos;
        logic               sm;
        logic               dm;
        logic               rm;
        logic               x;
        logic               n;
        logic               z;
        logic               v;
        logic               c;

        x = f[FLAG_X_BIT];
        n = f[FLAG_N_BIT];
        z = f[FLAG_Z_BIT];
        v = f[FLAG_V_BIT];
        c = f[FLAG_C_BIT];

        case (it.operand_size)
            SIZE_BYTE:
            begin
                mask = DATA_W'(32'h0000_00ff);
                span = SHIFT_W'(8);
            end
            SIZE_WORD:
            begin
                mask = DATA_W'(32'h0000_ffff);
                span = SHIFT_W'(16);
            end
            default:
            begin
                mask = '1;
                span = SHIFT_W'(DATA_W);
            end
        endcase

        s = it.src_operand & mask;
        d = it.dst_operand & mask;
        r = it.alu_result & mask;

        case (it.operand_size)
            SIZE_BYTE:
            begin
                sm = s[7];
                dm = d[7];
                rm = r[7];
            end
            SIZE_WORD:
            begin
                sm = s[15];
                dm = d[15];
                rm = r[15];
            end
            default:
            begin
                sm = s[DATA_W-1];
                dm = d[DATA_W-1];
                rm = r[DATA_W-1];
            end
        endcase

        rpos = it.shift_count - SHIFT_W'(1);
        lpos = span - it.shift_count;

        case (it.n_rule)
            N_SIGN:   n = rm;
            N_TOGGLE: n = !n;
            default:  n = n;
        endcase

        case (it.z_rule)
            Z_KEEP:   z = z;
            Z_TOGGLE: z = !z;
            Z_ZERO:   z = (r == '0);
            Z_STICKY: z = z && (r == '0);
            default:  z = z;
        endcase

        case (it.v_rule)
            V_CLEAR:  v = 1'b0;
            V_TOGGLE: v = !v;
            V_ADD:    v = (sm && dm && !rm) || (!sm && !dm && rm);
            V_SUB:    v = (!sm && dm && !rm) || (sm && !dm && rm);
            V_DR:     v = dm && rm;
            default:  v = v;
        endcase

        case (it.c_rule)
            C_TOGGLE:  c = !c;
            C_CLEAR:   c = 1'b0;
            C_COPY_X:  c = x;
            // bits above the operand top are masked to zero already
            C_SHR_OUT: c = (it.shift_count != '0) && (it.shift_count <= SHIFT_W'(DATA_W))
                           && d[rpos[IDX_W-1:0]];
            C_SHL_OUT: c = (it.shift_count != '0) && (it.shift_count <= span)
                           && d[lpos[IDX_W-1:0]];
            C_DR_SIGN: c = dm || rm;
            C_ADD:     c = (sm && dm) || (!rm && dm) || (sm && !rm);
            C_SUB:     c = (sm && !dm) || (rm && !dm) || (sm && rm);
            default:   c = c;
        endcase

        // x follows the new carry
        if (it.x_rule == X_COPY_C)
        begin
            x = c;
        end

        return {x, n, z, v, c};
    endfunction

    // branch condition against the current flags
    function automatic logic cond_test(input logic [3:0] sel, input logic [FLAG_W-1:0] f);
        logic n;
        logic z;
        logic v;
        logic c;
        logic t;

        n = f[FLAG_N_BIT];
        z = f[FLAG_Z_BIT];
        v = f[FLAG_V_BIT];
        c = f[FLAG_C_BIT];

        case (sel)
            COND_T:  t = 1'b1;
            COND_F:  t = 1'b0;
            COND_HI: t = !c && !z;
            COND_LS: t = c || z;
            COND_CC: t = !c;
            COND_CS: t = c;
            COND_NE: t = !z;
            COND_EQ: t = z;
            COND_VC: t = !v;
            COND_VS: t = v;
            COND_PL: t = !n;
            COND_MI: t = n;
            COND_GE: t = (n == v);
            COND_LT: t = (n != v);
            COND_GT: t = !z && (n == v);
            COND_LE: t = z || (n != v);
            default: t = 1'b0;
        endcase

        return t;
    endfunction

endpackage

// ===== src/ccfu_if.sv =====
// request and response channel interfaces

interface ccfu_req_if;
    import ccfu_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic               x_rule;
    logic [1:0]         n_rule;
    logic [1:0]         z_rule;
    logic [2:0]         v_rule;
    logic [3:0]         c_rule;
    logic [DATA_W-1:0]  src_operand;
    logic [DATA_W-1:0]  dst_operand;
    logic [DATA_W-1:0]  alu_result;
    logic [1:0]         operand_size;
    logic [SHIFT_W-1:0] shift_count;
    logic [3:0]         cond_select;

    modport source (
        output valid, action, x_rule, n_rule, z_rule, v_rule, c_rule,
               src_operand, dst_operand, alu_result, operand_size,
               shift_count, cond_select,
        input  ready
    );

    modport sink (
        input  valid, action, x_rule, n_rule, z_rule, v_rule, c_rule,
               src_operand, dst_operand, alu_result, operand_size,
               shift_count, cond_select,
        output ready
    );
endinterface

interface ccfu_rsp_if;
    import ccfu_pkg::*;

    logic              valid;
    logic              ready;
    logic [FLAG_W-1:0] flags_out;
    logic              cond_true;

    modport source (
        output valid, flags_out, cond_true,
        input  ready
    );

    modport sink (
        input  valid, flags_out, cond_true,
        output ready
    );
endinterface

// ===== src/condition_code_flag_unit.sv =====
// condition code flag unit top level: flag register, update and condition test
// path: a request transaction passes the input register, then the response register
// one transaction per cycle unless rsp stalls; the only loop is the 5-bit flag register
// with a response waiting, a request is taken only while the input stage is empty
// reset: rst_n low clears the flags and the input and response valid bits at once
module condition_code_flag_unit (
    input  logic       clk,
    input  logic       rst_n,
    ccfu_req_if.sink   req,
    ccfu_rsp_if.source rsp
);
    import ccfu_pkg::*;

    // input register
    logic              item_valid_reg;
    item_t             item_reg;

    // architectural flags
    logic [FLAG_W-1:0] flag_reg;
    logic [FLAG_W-1:0] flag_next;
    logic              cond_next;

    // response register
    logic              rsp_valid_reg;
    logic [FLAG_W-1:0] rsp_flags_reg;
    logic              rsp_cond_reg;

    logic              advance;
    logic              req_fire;

    // the response register can load when it is empty or being drained
    assign advance  = !rsp_valid_reg || rsp.ready;
    // the input stage frees up whenever its content moves on
    assign req.ready = !item_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    // flag update or condition test on the registered transaction
    always_comb
    begin
        flag_next = flag_reg;
        cond_next = 1'b0;
        if (item_reg.action == ACT_UPDATE)
        begin
            flag_next = flags_update(item_reg, flag_reg);
        end
        else
        begin
            cond_next = cond_test(item_reg.cond_select, flag_reg);
        end
    end

    // control state and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            flag_reg       <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                item_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= item_valid_reg;
                // flags move only when the transaction leaves the input stage
                if (item_valid_reg)
                begin
                    flag_reg <= flag_next;
                end
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg.action       <= req.action;
            item_reg.x_rule       <= req.x_rule;
            item_reg.n_rule       <= req.n_rule;
            item_reg.z_rule       <= req.z_rule;
            item_reg.v_rule       <= req.v_rule;
            item_reg.c_rule       <= req.c_rule;
            item_reg.src_operand  <= req.src_operand;
            item_reg.dst_operand  <= req.dst_operand;
            item_reg.alu_result   <= req.alu_result;
            item_reg.operand_size <= req.operand_size;
            item_reg.shift_count  <= req.shift_count;
            item_reg.cond_select  <= req.cond_select;
        end
        if (advance && item_valid_reg)
        begin
            rsp_flags_reg <= flag_next;
            rsp_cond_reg  <= cond_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.flags_out = rsp_flags_reg;
    assign rsp.cond_true = rsp_cond_reg;

endmodule

// ===== src/ccfu_checker.sv =====
// port-level assertion checker for the condition code flag unit, with its bind
`include "condition_code_flag_unit_defines.svh"

module ccfu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       req_action,
    input logic [3:0] req_cond_select,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [4:0] rsp_flags_out,
    input logic       rsp_cond_true
);
    import ccfu_pkg::*;

    // a stalled response keeps its payload
    `CCFU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_flags_out) && $stable(rsp_cond_true))

    // with nothing pending at the output the unit takes a request
    `CCFU_ASSERT_SAME(a_req_ready_empty, !rsp_valid, req_ready)

    // an accepted request shows up once the response register is free to load it
    `CCFU_ASSERT_NEXT(a_rsp_latency, (req_valid && req_ready) ##1 (!rsp_valid || rsp_ready), rsp_valid)

    // the always-true condition reports true
    `CCFU_ASSERT_NEXT(a_cond_always, (req_valid && req_ready && req_action == ACT_TEST && req_cond_select == COND_T) ##1 (!rsp_valid || rsp_ready), rsp_valid && rsp_cond_true)

    // update transactions never report a true condition
    `CCFU_ASSERT_NEXT(a_update_no_cond, (req_valid && req_ready && req_action == ACT_UPDATE) ##1 (!rsp_valid || rsp_ready), rsp_valid && !rsp_cond_true)

endmodule

bind condition_code_flag_unit ccfu_checker u_ccfu_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_action      (req.action),
    .req_cond_select (req.cond_select),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_flags_out   (rsp.flags_out),
    .rsp_cond_true   (rsp.cond_true)
);

// ===== tb/condition_code_flag_unit_checker.sv =====
// checker for the condition code flag unit: watches both channels, predicts flags and compares
module condition_code_flag_unit_checker
    import ccfu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ccfu_req_if  req,
    ccfu_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic [FLAG_W-1:0] flags;
        logic              taken;
    } flag_result_t;

    logic [FLAG_W-1:0] flag_state = '0;
    flag_result_t      flag_results_q[$];

    // flags after an update transaction
    function automatic logic [FLAG_W-1:0] next_flags(input item_t t,
                                                     input logic [FLAG_W-1:0] f);
        logic [DATA_W-1:0] width_mask;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] r;
        int                msb;
        int                cnt;
        logic              s_neg;
        logic              d_neg;
        logic              r_neg;
        logic              fx;
        logic              fn;
        logic              fz;
        logic              fv;
        logic              fc;

        fx = f[FLAG_X_BIT];
        fn = f[FLAG_N_BIT];
        fz = f[FLAG_Z_BIT];
        fv = f[FLAG_V_BIT];
        fc = f[FLAG_C_BIT];

        // size three behaves as long
        case (t.operand_size)
            SIZE_BYTE:
            begin
                width_mask = 32'h0000_00ff;
                msb = 7;
            end
            SIZE_WORD:
            begin
                width_mask = 32'h0000_ffff;
                msb = 15;
            end
            default:
            begin
                width_mask = 32'hffff_ffff;
                msb = 31;
            end
        endcase

        s = t.src_operand & width_mask;
        d = t.dst_operand & width_mask;
        r = t.alu_result & width_mask;
        s_neg = s[msb];
        d_neg = d[msb];
        r_neg = r[msb];
        cnt = int'(t.shift_count);

        if (t.n_rule == N_SIGN)
        begin
            fn = r_neg;
        end
        else if (t.n_rule == N_TOGGLE)
        begin
            fn = !fn;
        end

        case (t.z_rule)
            Z_TOGGLE: fz = !fz;
            Z_ZERO:   fz = (r == '0);
            Z_STICKY: fz = fz && (r == '0);
            default:  ;
        endcase

        case (t.v_rule)
            V_CLEAR:  fv = 1'b0;
            V_TOGGLE: fv = !fv;
            V_ADD:    fv = (s_neg && d_neg && !r_neg) || (!s_neg && !d_neg && r_neg);
            V_SUB:    fv = (!s_neg && d_neg && !r_neg) || (s_neg && !d_neg && r_neg);
            V_DR:     fv = d_neg && r_neg;
            default:  ;
        endcase

        // carry uses the old x; a bit position outside the operand gives 0
        case (t.c_rule)
            C_TOGGLE:  fc = !fc;
            C_CLEAR:   fc = 1'b0;
            C_COPY_X:  fc = fx;
            C_SHR_OUT: fc = (cnt >= 1 && cnt - 1 <= msb) ? d[cnt-1] : 1'b0;
            C_SHL_OUT: fc = (cnt >= 1 && cnt <= msb + 1) ? d[msb+1-cnt] : 1'b0;
            C_DR_SIGN: fc = d_neg || r_neg;
            C_ADD:     fc = (s_neg && d_neg) || (!r_neg && d_neg) || (s_neg && !r_neg);
            C_SUB:     fc = (s_neg && !d_neg) || (r_neg && !d_neg) || (s_neg && r_neg);
            default:   ;
        endcase

        if (t.x_rule == X_COPY_C)
        begin
            fx = fc;
        end

        return {fx, fn, fz, fv, fc};
    endfunction

    function automatic logic branch_taken(input logic [3:0] sel,
                                          input logic [FLAG_W-1:0] f);
        logic fn;
        logic fz;
        logic fv;
        logic fc;

        fn = f[FLAG_N_BIT];
        fz = f[FLAG_Z_BIT];
        fv = f[FLAG_V_BIT];
        fc = f[FLAG_C_BIT];

        case (sel)
            COND_T:  return 1'b1;
            COND_F:  return 1'b0;
            COND_HI: return !fc && !fz;
            COND_LS: return fc || fz;
            COND_CC: return !fc;
            COND_CS: return fc;
            COND_NE: return !fz;
            COND_EQ: return fz;
            COND_VC: return !fv;
            COND_VS: return fv;
            COND_PL: return !fn;
            COND_MI: return fn;
            COND_GE: return fn == fv;
            COND_LT: return fn != fv;
            COND_GT: return !fz && (fn == fv);
            default: return fz || (fn != fv);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        item_t        req_item;
        flag_result_t want;

        if (!rst_n)
        begin
            flag_state = '0;
            flag_results_q.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                req_item.action       = req.action;
                req_item.x_rule       = req.x_rule;
                req_item.n_rule       = req.n_rule;
                req_item.z_rule       = req.z_rule;
                req_item.v_rule       = req.v_rule;
                req_item.c_rule       = req.c_rule;
                req_item.src_operand  = req.src_operand;
                req_item.dst_operand  = req.dst_operand;
                req_item.alu_result   = req.alu_result;
                req_item.operand_size = req.operand_size;
                req_item.shift_count  = req.shift_count;
                req_item.cond_select  = req.cond_select;

                if (req_item.action == ACT_UPDATE)
                begin
                    want.flags = next_flags(req_item, flag_state);
                    want.taken = 1'b0;
                end
                else
                begin
                    want.flags = flag_state;
                    want.taken = branch_taken(req_item.cond_select, flag_state);
                end
                flag_state = want.flags;
                flag_results_q.push_back(want);
            end

            if (rsp.valid && rsp.ready)
            begin
                if (flag_results_q.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected response flags=%b cond=%b",
                                 rsp.flags_out, rsp.cond_true);
                    end
                    mismatches++;
                end
                else
                begin
                    want = flag_results_q.pop_front();
                    if (rsp.flags_out !== want.flags)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("flags_out mismatch: expected %b actual %b",
                                     want.flags, rsp.flags_out);
                        end
                        mismatches++;
                    end
                    if (rsp.cond_true !== want.taken)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("cond_true mismatch: expected %b actual %b",
                                     want.taken, rsp.cond_true);
                        end
                        mismatches++;
                    end
                end
            end

            outstanding = flag_results_q.size();
        end
    end

endmodule

// ===== tb/condition_code_flag_unit_test.sv =====
// top level testbench for the condition code flag unit: clock, reset, stimulus and verdict
module condition_code_flag_unit_test;
    import ccfu_pkg::*;

    // operand corner values: zero, all ones, sign bits at each size, size masks
    localparam logic [DATA_W-1:0] EDGE_VALUES [8] = '{
        32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
        32'h0000_0080, 32'h0000_8000, 32'h0000_00ff, 32'h0000_ffff
    };

    // shift counts around the operand boundaries, including zero and beyond long
    localparam logic [SHIFT_W-1:0] EDGE_SHIFTS [10] = '{
        6'd0, 6'd1, 6'd63, 6'd32, 6'd8, 6'd16, 6'd33, 6'd9, 6'd17, 6'd7
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // idle percentages, changed per phase by the stimulus process
    int tx_idle_pct = 9;
    int rx_idle_pct = 50;

    // asks the receiver for one long hold-off
    bit hold_now = 1'b0;

    int mismatch_total;
    int results_owed;

    ccfu_req_if req_ch();
    ccfu_rsp_if rsp_ch();

    condition_code_flag_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    condition_code_flag_unit_checker flag_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatch_total),
        .outstanding (results_owed)
    );

    always #5 clk = ~clk;

    // hard limit: far beyond the slowest legal run of this stimulus
    initial
    begin
        #2000000;
        $display("condition_code_flag_unit verification failed");
        $finish;
    end

    // operand mix: zero, zero in the low byte or word, single bits, full random
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(4))
            0:       return '0;
            1:       return $urandom & 32'hffff_ff00;
            2:       return $urandom & 32'hffff_0000;
            3:       return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // drives one transaction from a falling edge and returns at the falling edge
    // after it was accepted; valid stays high when the next one follows at once
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= it.action;
        req_ch.x_rule       <= it.x_rule;
        req_ch.n_rule       <= it.n_rule;
        req_ch.z_rule       <= it.z_rule;
        req_ch.v_rule       <= it.v_rule;
        req_ch.c_rule       <= it.c_rule;
        req_ch.src_operand  <= it.src_operand;
        req_ch.dst_operand  <= it.dst_operand;
        req_ch.alu_result   <= it.alu_result;
        req_ch.operand_size <= it.operand_size;
        req_ch.shift_count  <= it.shift_count;
        req_ch.cond_select  <= it.cond_select;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // response side: random stalls at the phase rate, plus one long hold-off
    // counted here so the sender keeps offering while the block backs up
    initial
    begin
        int hold_left;

        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_now)
            begin
                hold_now = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        item_t it;

        // all request inputs known from time zero
        req_ch.valid        = 1'b0;
        req_ch.action       = ACT_UPDATE;
        req_ch.x_rule       = 1'b0;
        req_ch.n_rule       = '0;
        req_ch.z_rule       = Z_KEEP;
        req_ch.v_rule       = '0;
        req_ch.c_rule       = '0;
        req_ch.src_operand  = '0;
        req_ch.dst_operand  = '0;
        req_ch.alu_result   = '0;
        req_ch.operand_size = SIZE_BYTE;
        req_ch.shift_count  = '0;
        req_ch.cond_select  = COND_T;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part: every rule code on corner operands and sizes, with
        // size three, unused codes, zero and out-of-range shift counts, and
        // carry taken from old x while x follows the new carry; every branch
        // condition is tested against the flags as they evolve
        for (int k = 0; k < 16; k++)
        begin
            if (k < 10)
            begin
                it = '0;
                it.action       = ACT_UPDATE;
                it.x_rule       = 1'(k);
                it.n_rule       = 2'(k);
                it.z_rule       = 2'(k >> 1);
                it.v_rule       = 3'(k);
                it.c_rule       = (k < 9) ? 4'(k) : 4'd12;
                it.src_operand  = EDGE_VALUES[k % 8];
                it.dst_operand  = EDGE_VALUES[(k + 3) % 8];
                it.alu_result   = EDGE_VALUES[(k + 5) % 8];
                it.operand_size = 2'(k);
                it.shift_count  = EDGE_SHIFTS[k];
                send_item(it);
            end
            it = '0;
            it.action      = ACT_TEST;
            it.cond_select = 4'(k);
            send_item(it);
        end

        // random part in three idle phases; the last one carries the hold-off
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 50;
                end
                1:
                begin
                    tx_idle_pct = 50;
                    rx_idle_pct = 9;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_now = 1'b1;
                end
            endcase

            for (int i = 0; i < 360; i++)
            begin
                it.action       = ($urandom_range(99) < 35) ? ACT_TEST : ACT_UPDATE;
                it.x_rule       = 1'($urandom);
                it.n_rule       = 2'($urandom);
                it.z_rule       = 2'($urandom);
                it.v_rule       = 3'($urandom);
                // mostly defined carry rules, sometimes the unused codes
                it.c_rule       = ($urandom_range(3) == 0) ? 4'($urandom)
                                                           : 4'($urandom_range(8));
                it.src_operand  = pick_operand();
                it.dst_operand  = pick_operand();
                it.alu_result   = pick_operand();
                it.operand_size = 2'($urandom);
                // counts near the operand widths most of the time
                it.shift_count  = ($urandom_range(3) == 0) ? 6'($urandom)
                                                           : 6'($urandom_range(33));
                it.cond_select  = 4'($urandom);
                send_item(it);
            end
        end

        req_ch.valid <= 1'b0;

        // drain, then keep watching for anything stray from the two-stage path
        while (results_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (mismatch_total == 0 && results_owed == 0)
        begin
            $display("condition_code_flag_unit verification clean");
        end
        else
        begin
            $display("condition_code_flag_unit verification failed");
        end
        $finish;
    end

endmodule
